@@ rtl/vmla_pkg.sv @@
// Shared constants for the look-at view matrix block.
// Used by vmla_norm and view_matrix_look_at; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vmla_pkg;

    // Width of every input and result field.
    localparam int FIELD_W = 32;

    // The largest of the three magnitudes is brought to [2^(MAG_BITS-1), 2^MAG_BITS).
    localparam int MAG_BITS = 30;

    // Result bits of the square root of a sum of three squared magnitudes.
    localparam int SQRT_STEPS = MAG_BITS + 1;

    // Stages of the normalizer that do not depend on the fraction width.
    localparam int NORM_LAT_FIXED = 5 + SQRT_STEPS + 3;

endpackage

`default_nettype wire

@@ rtl/view_matrix_look_at.sv @@
// Top level of the look-at view matrix block: forward, right and true up
// rows with their translations. Depends on vmla_pkg and vmla_norm.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// A camera setup (eye, target, up hint, signed fixed point with FRAC_BITS
// fraction bits) transfers in at a rising edge with start high and busy
// low. busy is low whenever reset is released, so a new setup may enter
// in every cycle. The matrix rows leave on the o_ ports with o_valid high
// for exactly one cycle. The pipeline is made of the two normalizers, each
// a one-bit-per-stage square root of 31 stages and a one-bit-per-stage
// divider of FRAC_BITS+1 stages, plus the cross product, rounding and
// translation stages around them.
// Throughput is one setup per cycle; results come out in input order.
// The receiver cannot stall; each result is shown for one cycle only.
// Synchronous reset empties the pipeline: no result emerges for any setup
// still in flight, and busy stays high while reset is held.
module view_matrix_look_at #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_eye_x,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_eye_y,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_eye_z,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_target_x,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_target_y,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_target_z,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_up_hint_x,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_up_hint_y,
    input  logic signed [vmla_pkg::FIELD_W-1:0]    i_up_hint_z,
    output logic                                   o_valid,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_right_x,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_right_y,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_right_z,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_shift_right,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_true_up_x,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_true_up_y,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_true_up_z,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_shift_up,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_fwd_x,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_fwd_y,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_fwd_z,
    output logic signed [vmla_pkg::FIELD_W-1:0]    o_shift_fwd
);
    import vmla_pkg::*;

    localparam int FW   = FIELD_W;
    localparam int DW0  = FW + 1;
    localparam int QW   = FRAC_BITS + 2;
    localparam int P1   = FW + QW;
    localparam int CW   = P1 + 1;
    localparam int XP   = 2 * QW;
    localparam int DW   = XP + 1;
    localparam int RW   = FRAC_BITS + 7;
    localparam int TPW  = RW + FW;
    localparam int SW2  = TPW + 2;
    localparam int QW2  = SW2 + 1;
    localparam int S1W  = 6 * FW;
    localparam int S2W  = 3 * FW + 3 * QW;

    // Any accepted transfer needs reset released.
    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    logic signed [FW-1:0] w_eye [3];
    logic signed [FW-1:0] w_tgt [3];
    logic signed [FW-1:0] w_up  [3];

    assign w_eye = '{i_eye_x, i_eye_y, i_eye_z};
    assign w_tgt = '{i_target_x, i_target_y, i_target_z};
    assign w_up  = '{i_up_hint_x, i_up_hint_y, i_up_hint_z};

    // Stage 1: exact differences eye minus target.
    logic                  r1_valid;
    logic signed [DW0-1:0] r1_diff [3];
    logic [S1W-1:0]        r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        for (int i = 0; i < 3; i++) begin
            r1_diff[i]               <= DW0'(w_eye[i]) - DW0'(w_tgt[i]);
            r1_side[i*FW +: FW]      <= w_eye[i];
            r1_side[(3+i)*FW +: FW]  <= w_up[i];
        end
    end

    // Forward row.
    logic                 w_n1_valid;
    logic signed [QW-1:0] w_fwd [3];
    logic [S1W-1:0]       w_n1_side;

    vmla_norm #(
        .W         (DW0),
        .FRAC_BITS (FRAC_BITS),
        .SW        (S1W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .i_v     (r1_diff),
        .i_side  (r1_side),
        .o_valid (w_n1_valid),
        .o_q     (w_fwd),
        .o_side  (w_n1_side)
    );

    // Stage 2: products of up hint cross forward.
    logic                 r2_valid;
    logic signed [P1-1:0] r2_p [6];
    logic [S2W-1:0]       r2_side;
    logic signed [FW-1:0] w_u [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_u[i] = w_n1_side[(3+i)*FW +: FW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= w_n1_valid;
        end
        r2_p[0] <= w_u[1] * w_fwd[2];
        r2_p[1] <= w_u[2] * w_fwd[1];
        r2_p[2] <= w_u[2] * w_fwd[0];
        r2_p[3] <= w_u[0] * w_fwd[2];
        r2_p[4] <= w_u[0] * w_fwd[1];
        r2_p[5] <= w_u[1] * w_fwd[0];
        for (int i = 0; i < 3; i++) begin
            r2_side[i*FW +: FW]          <= w_n1_side[i*FW +: FW];
            r2_side[3*FW + i*QW +: QW]   <= w_fwd[i];
        end
    end

    // Stage 3: exact cross product.
    logic                 r3_valid;
    logic signed [CW-1:0] r3_cr [3];
    logic [S2W-1:0]       r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r3_cr[i] <= CW'(r2_p[2*i]) - CW'(r2_p[2*i+1]);
        end
        r3_side <= r2_side;
    end

    // Right row.
    logic                 w_n2_valid;
    logic signed [QW-1:0] w_rgt [3];
    logic [S2W-1:0]       w_n2_side;

    vmla_norm #(
        .W         (CW),
        .FRAC_BITS (FRAC_BITS),
        .SW        (S2W)
    ) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_v     (r3_cr),
        .i_side  (r3_side),
        .o_valid (w_n2_valid),
        .o_q     (w_rgt),
        .o_side  (w_n2_side)
    );

    logic signed [QW-1:0] w_f2 [3];
    logic signed [FW-1:0] w_e2 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e2[i] = w_n2_side[i*FW +: FW];
            w_f2[i] = w_n2_side[3*FW + i*QW +: QW];
        end
    end

    // Stage 4: products of forward cross right.
    logic                 r4_valid;
    logic signed [XP-1:0] r4_p [6];
    logic signed [FW-1:0] r4_eye [3];
    logic signed [QW-1:0] r4_fwd [3];
    logic signed [QW-1:0] r4_rgt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= w_n2_valid;
        end
        r4_p[0] <= w_f2[1] * w_rgt[2];
        r4_p[1] <= w_f2[2] * w_rgt[1];
        r4_p[2] <= w_f2[2] * w_rgt[0];
        r4_p[3] <= w_f2[0] * w_rgt[2];
        r4_p[4] <= w_f2[0] * w_rgt[1];
        r4_p[5] <= w_f2[1] * w_rgt[0];
        r4_eye  <= w_e2;
        r4_fwd  <= w_f2;
        r4_rgt  <= w_rgt;
    end

    // Stage 5: exact product differences.
    logic                 r5_valid;
    logic signed [DW-1:0] r5_d [3];
    logic signed [FW-1:0] r5_eye [3];
    logic signed [QW-1:0] r5_fwd [3];
    logic signed [QW-1:0] r5_rgt [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r5_d[i] <= DW'(r4_p[2*i]) - DW'(r4_p[2*i+1]);
        end
        r5_eye <= r4_eye;
        r5_fwd <= r4_fwd;
        r5_rgt <= r4_rgt;
    end

    // Stage 6: round the true up row half away from zero.
    logic [DW-1:0]        n5_mag [3];
    logic [DW:0]          n5_q [3];
    logic                 r6_valid;
    logic signed [RW-1:0] r6_tup [3];
    logic signed [FW-1:0] r6_eye [3];
    logic signed [QW-1:0] r6_fwd [3];
    logic signed [QW-1:0] r6_rgt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_mag[i] = r5_d[i][DW-1] ? DW'(-r5_d[i]) : DW'(r5_d[i]);
            n5_q[i]   = ((DW+1)'(n5_mag[i]) + ((DW+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        for (int i = 0; i < 3; i++) begin
            if (r5_d[i][DW-1]) begin
                r6_tup[i] <= -$signed(n5_q[i][RW-1:0]);
            end else begin
                r6_tup[i] <= $signed(n5_q[i][RW-1:0]);
            end
        end
        r6_eye <= r5_eye;
        r6_fwd <= r5_fwd;
        r6_rgt <= r5_rgt;
    end

    // Stage 7: row times eye products; rows 0, 1, 2 are right, up, forward.
    logic signed [RW-1:0]  w_row [3][3];
    logic                  r7_valid;
    logic signed [TPW-1:0] r7_p [3][3];
    logic signed [RW-1:0]  r7_row [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_row[0][i] = RW'(r6_rgt[i]);
            w_row[1][i] = r6_tup[i];
            w_row[2][i] = RW'(r6_fwd[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
                r7_p[r][i] <= w_row[r][i] * r6_eye[i];
            end
        end
        r7_row <= w_row;
    end

    // Stage 8: dot product sums.
    logic                  r8_valid;
    logic signed [SW2-1:0] r8_s [3];
    logic signed [RW-1:0]  r8_row [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else begin
            r8_valid <= r7_valid;
        end
        for (int r = 0; r < 3; r++) begin
            r8_s[r] <= SW2'(r7_p[r][0]) + SW2'(r7_p[r][1]) + SW2'(r7_p[r][2]);
        end
        r8_row <= r7_row;
    end

    // Stage 9: round, negate and saturate the translations.
    localparam logic [QW2-1:0] LIM_NEG = QW2'(1) << (FW - 1);
    localparam logic [QW2-1:0] LIM_POS = LIM_NEG - QW2'(1);

    logic [SW2-1:0]       n8_mag [3];
    logic [QW2-1:0]       n8_q [3];
    logic [FW-1:0]        n8_t [3];
    logic                 r9_valid;
    logic signed [FW-1:0] r9_t [3];
    logic signed [FW-1:0] r9_row [3][3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n8_mag[r] = r8_s[r][SW2-1] ? SW2'(-r8_s[r]) : SW2'(r8_s[r]);
            n8_q[r]   = (QW2'(n8_mag[r]) + (QW2'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (r8_s[r][SW2-1]) begin
                n8_t[r] = (n8_q[r] > LIM_POS) ? LIM_POS[FW-1:0] : n8_q[r][FW-1:0];
            end else begin
                n8_t[r] = (n8_q[r] > LIM_NEG) ? LIM_NEG[FW-1:0] : (~n8_q[r][FW-1:0]) + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else begin
            r9_valid <= r8_valid;
        end
        for (int r = 0; r < 3; r++) begin
            r9_t[r] <= $signed(n8_t[r]);
            for (int i = 0; i < 3; i++) begin
                r9_row[r][i] <= FW'(r8_row[r][i]);
            end
        end
    end

    assign o_valid       = r9_valid;
    assign o_right_x     = r9_row[0][0];
    assign o_right_y     = r9_row[0][1];
    assign o_right_z     = r9_row[0][2];
    assign o_shift_right = r9_t[0];
    assign o_true_up_x   = r9_row[1][0];
    assign o_true_up_y   = r9_row[1][1];
    assign o_true_up_z   = r9_row[1][2];
    assign o_shift_up    = r9_t[1];
    assign o_fwd_x       = r9_row[2][0];
    assign o_fwd_y       = r9_row[2][1];
    assign o_fwd_z       = r9_row[2][2];
    assign o_shift_fwd   = r9_t[2];

`ifndef SYNTHESIS
    localparam logic signed [FW-1:0] ONE = FW'(1) <<< FRAC_BITS;

    // A zero forward row forces the right row and the forward translation to zero.
    a_fwd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fwd_x == 0 && o_fwd_y == 0 && o_fwd_z == 0) |->
        (o_right_x == 0 && o_right_y == 0 && o_right_z == 0 && o_shift_fwd == 0))
        else $error("forward is zero but right or forward translation is not");

    // A zero right row forces the true up row and two translations to zero.
    a_right_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_right_x == 0 && o_right_y == 0 && o_right_z == 0) |->
        (o_true_up_x == 0 && o_true_up_y == 0 && o_true_up_z == 0 &&
         o_shift_right == 0 && o_shift_up == 0))
        else $error("right is zero but true up or its translations are not");

    // The forward x and right y components never exceed one in magnitude.
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fwd_x <= ONE && o_fwd_x >= -ONE && o_right_y <= ONE &&
                     o_right_y >= -ONE))
        else $error("normalized component out of range");

    // Reset flushes the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/vmla_norm.sv @@
// Pipelined vector normalizer: magnitude scaling, squared length, a
// one-bit-per-stage square root and a one-bit-per-stage divider.
// Depends on vmla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vmla_norm #(
    parameter int W         = 33,
    parameter int FRAC_BITS = 16,
    parameter int SW        = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [W-1:0]        i_v [3],
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic signed [FRAC_BITS+1:0] o_q [3],
    output logic [SW-1:0]              o_side
);
    import vmla_pkg::*;

    localparam int PW   = $clog2(W);
    localparam int EW   = W + MAG_BITS;
    localparam int SQW  = 2 * MAG_BITS + 2;
    localparam int LW   = MAG_BITS + 1;
    localparam int QB   = FRAC_BITS + 1;
    localparam int NW   = LW + FRAC_BITS;
    localparam int QW   = FRAC_BITS + 2;
    localparam int MW   = SW + 4;
    localparam int TOP  = MAG_BITS - 1;
    localparam int SQN  = SQRT_STEPS;

    // Stage 1: magnitudes and signs.
    logic           r1_valid;
    logic [W-1:0]   r1_mag [3];
    logic [2:0]     r1_neg;
    logic [SW-1:0]  r1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r1_mag[i] <= i_v[i][W-1] ? W'(-i_v[i]) : W'(i_v[i]);
            r1_neg[i] <= i_v[i][W-1];
        end
        r1_side <= i_side;
    end

    // Stage 2: leading one of the largest magnitude and the scaling shift.
    logic [W-1:0]   n_or;
    logic [PW-1:0]  n_pos;
    logic           r2_valid;
    logic [W-1:0]   r2_mag [3];
    logic           r2_shr;
    logic [PW-1:0]  r2_sh;
    logic [MW-1:0]  r2_meta;

    always_comb begin
        n_or  = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n_pos = '0;
        for (int b = 0; b < W; b++) begin
            if (n_or[b]) begin
                n_pos = PW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_mag  <= r1_mag;
        r2_shr  <= n_pos > PW'(TOP);
        r2_sh   <= (n_pos > PW'(TOP)) ? n_pos - PW'(TOP) : PW'(TOP) - n_pos;
        r2_meta <= {r1_neg, n_or == '0, r1_side};
    end

    // Stage 3: scale all magnitudes together.
    logic [EW-1:0]       n_scaled [3];
    logic                r3_valid;
    logic [MAG_BITS-1:0] r3_a [3];
    logic [MW-1:0]       r3_meta;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_scaled[i] = r2_shr ? (EW'(r2_mag[i]) >> r2_sh) : (EW'(r2_mag[i]) << r2_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r3_a[i] <= n_scaled[i][MAG_BITS-1:0];
        end
        r3_meta <= r2_meta;
    end

    // Stage 4: squares.
    logic                  r4_valid;
    logic [MAG_BITS-1:0]   r4_a [3];
    logic [2*MAG_BITS-1:0] r4_sq [3];
    logic [MW-1:0]         r4_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= r3_a[i] * r3_a[i];
        end
        r4_a    <= r3_a;
        r4_meta <= r3_meta;
    end

    // Square root pipeline; entry 0 holds the squared length.
    logic                r_sv [0:SQN];
    logic [SQW-1:0]      r_sn [0:SQN];
    logic [SQW-1:0]      r_sr [0:SQN];
    logic [MAG_BITS-1:0] r_sa [0:SQN][3];
    logic [MW-1:0]       r_sm [0:SQN];
    logic [SQW-1:0]      n_sn [1:SQN];
    logic [SQW-1:0]      n_sr [1:SQN];

    always_comb begin
        for (int k = 0; k < SQN; k++) begin
            logic [SQW-1:0] bitv;
            logic [SQW-1:0] trial;
            bitv  = SQW'(1) << (2 * (SQN - 1 - k));
            trial = r_sr[k] + bitv;
            if (r_sn[k] >= trial) begin
                n_sn[k+1] = r_sn[k] - trial;
                n_sr[k+1] = (r_sr[k] >> 1) + bitv;
            end else begin
                n_sn[k+1] = r_sn[k];
                n_sr[k+1] = r_sr[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQN; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else begin
            r_sv[0] <= r4_valid;
            for (int k = 0; k < SQN; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
        end
        r_sn[0] <= SQW'(r4_sq[0]) + SQW'(r4_sq[1]) + SQW'(r4_sq[2]);
        r_sr[0] <= '0;
        r_sa[0] <= r4_a;
        r_sm[0] <= r4_meta;
        for (int k = 0; k < SQN; k++) begin
            r_sn[k+1] <= n_sn[k+1];
            r_sr[k+1] <= n_sr[k+1];
            r_sa[k+1] <= r_sa[k];
            r_sm[k+1] <= r_sm[k];
        end
    end

    // Divider pipeline; entry 0 holds the rounded numerators and the length.
    logic [LW-1:0]  w_len;
    logic           r_dv [0:QB];
    logic [NW-1:0]  r_dn [0:QB][3];
    logic [QB-1:0]  r_dq [0:QB][3];
    logic [LW-1:0]  r_dd [0:QB];
    logic [MW-1:0]  r_dm [0:QB];
    logic [NW-1:0]  n_dn [1:QB][3];
    logic [QB-1:0]  n_dq [1:QB][3];

    assign w_len = r_sr[SQN][LW-1:0];

    always_comb begin
        for (int j = 0; j < QB; j++) begin
            logic [NW-1:0] dsh;
            dsh = NW'(r_dd[j]) << (QB - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (r_dn[j][i] >= dsh) begin
                    n_dn[j+1][i] = r_dn[j][i] - dsh;
                    n_dq[j+1][i] = r_dq[j][i] | (QB'(1) << (QB - 1 - j));
                end else begin
                    n_dn[j+1][i] = r_dn[j][i];
                    n_dq[j+1][i] = r_dq[j][i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QB; j++) begin
                r_dv[j] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_sv[SQN];
            for (int j = 0; j < QB; j++) begin
                r_dv[j+1] <= r_dv[j];
            end
        end
        for (int i = 0; i < 3; i++) begin
            r_dn[0][i] <= (NW'(r_sa[SQN][i]) << FRAC_BITS) + NW'(w_len >> 1);
            r_dq[0][i] <= '0;
        end
        r_dd[0] <= w_len;
        r_dm[0] <= r_sm[SQN];
        for (int j = 0; j < QB; j++) begin
            r_dn[j+1] <= n_dn[j+1];
            r_dq[j+1] <= n_dq[j+1];
            r_dd[j+1] <= r_dd[j];
            r_dm[j+1] <= r_dm[j];
        end
    end

    // Output stage: apply signs, force a zero vector to zero.
    logic                 r_ov;
    logic signed [QW-1:0] r_oq [3];
    logic [SW-1:0]        r_os;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dv[QB];
        end
        for (int i = 0; i < 3; i++) begin
            if (r_dm[QB][SW]) begin
                r_oq[i] <= '0;
            end else if (r_dm[QB][SW+1+i]) begin
                r_oq[i] <= -$signed(QW'(r_dq[QB][i]));
            end else begin
                r_oq[i] <= $signed(QW'(r_dq[QB][i]));
            end
        end
        r_os <= r_dm[QB][SW-1:0];
    end

    assign o_valid = r_ov;
    assign o_q     = r_oq;
    assign o_side  = r_os;

endmodule

`default_nettype wire
